// ----- sv/tstm_pkg.sv -----
// tstm_pkg: shared types, codes and helpers for the tab slot to midi event unit
`timescale 1ns / 1ps
package tstm_pkg;

    // string event byte codes
    localparam logic [7:0] EV_REST    = 8'h00;
    localparam logic [7:0] EV_MUTED   = 8'h11;
    localparam logic [7:0] EV_STOPPED = 8'h12;

    // track effect letters
    localparam logic [7:0] FX_INSTR  = 8'h49; // 'I'
    localparam logic [7:0] FX_VOLUME = 8'h56; // 'V'
    localparam logic [7:0] FX_CHORUS = 8'h43; // 'C'
    localparam logic [7:0] FX_PAN    = 8'h50; // 'P'
    localparam logic [7:0] FX_REVERB = 8'h52; // 'R'

    // controller numbers
    localparam logic [7:0] CTL_CHORUS = 8'h5d;
    localparam logic [7:0] CTL_PAN    = 8'h0a;
    localparam logic [7:0] CTL_REVERB = 8'h5b;

    // midi status nibbles
    localparam logic [3:0] ST_NOTE_OFF = 4'h8;
    localparam logic [3:0] ST_NOTE_ON  = 4'h9;
    localparam logic [3:0] ST_CONTROL  = 4'hb;
    localparam logic [3:0] ST_PROGRAM  = 4'hc;

    localparam int unsigned ACC_W   = 48;
    localparam int unsigned TICK_W  = 32;
    localparam int unsigned DELTA_W = 28;
    localparam int unsigned NSTR    = 8;
    localparam int unsigned PEND_W  = 2 * NSTR + 1;
    localparam int unsigned PIDX_W  = 5;

    // configuration register indexes
    typedef enum logic [2:0] {
        CFG_CHANNEL    = 3'd0,
        CFG_STRINGS    = 3'd1,
        CFG_INSTRUMENT = 3'd2,
        CFG_VOLUME     = 3'd3,
        CFG_TUNING     = 3'd4,
        CFG_TRANSPOSE  = 3'd5
    } t_cfg_idx;

    typedef enum logic [1:0] {
        S_IDLE,
        S_RUN
    } t_state;

    // controller to datapath
    typedef struct packed {
        logic load;
        logic emit;
        logic commit;
    } t_cmd;

    // datapath to controller
    typedef struct packed {
        logic pend_any;
        logic div_done;
        logic out_free;
    } t_status;

    // open-string base note per string
    function automatic logic [7:0] base_note(input logic [2:0] s);
        logic [7:0] b;
        case (s)
            3'd0:    b = 8'h28;
            3'd1:    b = 8'h2d;
            3'd2:    b = 8'h32;
            3'd3:    b = 8'h37;
            3'd4:    b = 8'h3b;
            3'd5:    b = 8'h40;
            default: b = 8'h00;
        endcase
        return b;
    endfunction

    // note number from event byte, tuning, transpose, string base and an 0x80 offset, mod 256
    function automatic logic [7:0] note_of(input logic [7:0] ev, input logic [7:0] tune,
                                          input logic [7:0] tr, input logic [2:0] s);
        return ev + tune + tr + base_note(s) + 8'h80;
    endfunction

endpackage

// ----- sv/tstm_if.sv -----
// tstm_if: slot request and midi event channel interfaces
`timescale 1ns / 1ps
interface tstm_slot_if;
    logic        valid;
    logic        ready;
    logic        action;
    logic [63:0] string_events;
    logic [7:0]  effect_code;
    logic [7:0]  effect_value;
    logic [7:0]  region_denominator;
    logic [7:0]  region_numerator;

    modport source (output valid, action, string_events, effect_code, effect_value,
                    region_denominator, region_numerator, input ready);
    modport sink (input valid, action, string_events, effect_code, effect_value,
                  region_denominator, region_numerator, output ready);
endinterface

interface tstm_event_if;
    logic        valid;
    logic        ready;
    logic [27:0] delta_ticks;
    logic [7:0]  status_byte;
    logic [7:0]  data_one;
    logic [7:0]  data_two;
    logic [1:0]  data_count;
    logic        last_event;

    modport source (output valid, delta_ticks, status_byte, data_one, data_two,
                    data_count, last_event, input ready);
    modport sink (input valid, delta_ticks, status_byte, data_one, data_two,
                  data_count, last_event, output ready);
endinterface

// ----- sv/tstm_div.sv -----
// tstm_div: restoring divider, one quotient bit per cycle, 8-bit divisor
`timescale 1ns / 1ps
module tstm_div #(
    parameter int unsigned DW = 30
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_start,
    input  logic [DW-1:0] i_dividend,
    input  logic [7:0]    i_divisor,
    output logic          o_done,
    output logic [DW-1:0] o_quotient
);
    localparam int unsigned CW = $clog2(DW + 1);

    logic          r_busy;
    logic [CW-1:0] r_cnt;
    logic [DW-1:0] r_q;
    logic [7:0]    r_rem;
    logic [7:0]    r_div;
    logic [8:0]    trial;
    logic          qbit;

    // trial subtract of the next partial remainder
    always_comb begin
        trial = {r_rem, r_q[DW-1]};
        qbit  = (trial >= {1'b0, r_div});
    end

    // control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_cnt  <= '0;
        end else if (i_start) begin
            r_busy <= 1'b1;
            r_cnt  <= CW'(DW);
        end else if (r_busy) begin
            r_cnt  <= r_cnt - 1'b1;
            if (r_cnt == CW'(1)) begin
                r_busy <= 1'b0;
            end
        end
    end

    // shift and subtract
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_q   <= i_dividend;
            r_rem <= '0;
            r_div <= i_divisor;
        end else if (r_busy) begin
            r_q   <= {r_q[DW-2:0], qbit};
            r_rem <= qbit ? 8'(trial - {1'b0, r_div}) : trial[7:0];
        end
    end

    assign o_done     = !r_busy;
    assign o_quotient = r_q;
endmodule

// ----- sv/tstm_ctrl.sv -----
// tstm_ctrl: request sequencing state machine
`timescale 1ns / 1ps
module tstm_ctrl (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_req_valid,
    output logic             o_req_ready,
    input  tstm_pkg::t_status i_status,
    output tstm_pkg::t_cmd    o_cmd
);
    import tstm_pkg::*;

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (i_req_valid) n_state = S_RUN;
            end
            S_RUN: begin
                if (!i_status.pend_any && i_status.div_done) n_state = S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase
    end

    // outputs
    always_comb begin
        o_cmd       = '0;
        o_req_ready = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                o_req_ready = 1'b1;
                o_cmd.load  = i_req_valid;
            end
            S_RUN: begin
                o_cmd.emit   = i_status.pend_any && i_status.out_free;
                o_cmd.commit = !i_status.pend_any && i_status.div_done;
            end
            default: ;
        endcase
    end
endmodule

// ----- sv/tstm_dp.sv -----
// tstm_dp: string state, event selection, output register and tick position
`timescale 1ns / 1ps
module tstm_dp #(
    parameter int unsigned STRINGS        = 8,
    parameter int unsigned TICKS_PER_SLOT = 24,
    parameter int unsigned FRACTION_BITS  = 16
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_cfg_we,
    input  logic [2:0]         i_cfg_idx,
    input  logic [63:0]        i_cfg_data,
    input  logic               i_action,
    input  logic [63:0]        i_string_events,
    input  logic [7:0]         i_effect_code,
    input  logic [7:0]         i_effect_value,
    input  logic [7:0]         i_region_denominator,
    input  logic [7:0]         i_region_numerator,
    input  tstm_pkg::t_cmd     i_cmd,
    output tstm_pkg::t_status  o_status,
    input  logic               i_out_ready,
    output logic               o_out_valid,
    output logic [27:0]        o_delta_ticks,
    output logic [7:0]         o_status_byte,
    output logic [7:0]         o_data_one,
    output logic [7:0]         o_data_two,
    output logic [1:0]         o_data_count,
    output logic               o_last_event
);
    import tstm_pkg::*;

    localparam int unsigned DW  = 8 + $clog2(TICKS_PER_SLOT + 1) + FRACTION_BITS + 1;
    localparam int unsigned SW  = ACC_W + TICK_W;
    localparam logic [SW-1:0] HALF = SW'(1) << (FRACTION_BITS - 1);

    // configuration
    logic [3:0]  r_channel;
    logic [3:0]  r_string_count;
    logic [63:0] r_tuning;
    logic [7:0]  r_transpose;

    // track state
    logic [7:0]        r_sound [NSTR];
    logic [ACC_W-1:0]  r_acc;
    logic [TICK_W-1:0] r_prev;
    logic              r_nlr;
    logic [6:0]        r_prog;
    logic [7:0]        r_vel;

    // per-request working state
    logic [7:0]        r_ev  [NSTR];
    logic [7:0]        r_off [NSTR];
    logic [PEND_W-1:0] r_pend;
    logic [7:0]        r_code;
    logic [7:0]        r_val;
    logic [TICK_W-1:0] r_tick;
    logic              r_flush;

    // output register
    logic        r_ovalid;
    logic [27:0] r_odelta;
    logic [7:0]  r_ostat;
    logic [7:0]  r_od1;
    logic [7:0]  r_od2;
    logic [1:0]  r_ocnt;
    logic        r_olast;

    // load-time decisions
    logic [NSTR-1:0]   used;
    logic [7:0]        ev_in   [NSTR];
    logic [7:0]        n_sound [NSTR];
    logic [7:0]        n_off   [NSTR];
    logic [PEND_W-1:0] n_pend;
    logic              any_ev;
    logic              fx_event;
    logic [SW-1:0]     tick_sum;

    // divider
    logic [7:0]    num_eff;
    logic [DW-1:0] prod;
    logic [DW-1:0] dividend;
    logic          div_start;
    logic          div_done;
    logic [DW-1:0] quotient;

    // event selection
    logic [PIDX_W-1:0] pidx;
    logic [PIDX_W-1:0] on_i;
    logic [PEND_W-1:0] pick;
    logic [2:0]        sel_s;
    logic [7:0]        sel_off;
    logic [7:0]        sel_ev;
    logic [7:0]        sel_tune;
    logic [TICK_W-1:0] dlt;
    logic [27:0]       dlt_sat;
    logic [3:0]        e_stat;
    logic [7:0]        e_d1;
    logic [7:0]        e_d2;
    logic [1:0]        e_cnt;

    // string state update for an incoming request
    always_comb begin
        any_ev = 1'b0;
        for (int s = 0; s < NSTR; s++) begin
            used[s]  = (4'(s) < r_string_count) && (s < STRINGS);
            ev_in[s] = i_string_events[8*s +: 8];
            if (used[s] && ev_in[s] != EV_REST) any_ev = 1'b1;
        end
        n_pend = '0;
        for (int s = 0; s < NSTR; s++) begin
            n_sound[s] = r_sound[s];
            n_off[s]   = '0;
            if (i_action) begin
                if (used[s]) begin
                    n_off[s]   = r_sound[s];
                    n_sound[s] = '0;
                end
            end else if (used[s] && ((r_nlr && any_ev) || (!r_nlr && ev_in[s] != EV_REST))) begin
                n_off[s]   = r_sound[s];
                n_sound[s] = (ev_in[s] == EV_MUTED || ev_in[s] == EV_STOPPED) ? 8'h00 : ev_in[s];
            end
            n_pend[s] = (n_off[s] != 8'h00);
            n_pend[NSTR + 1 + s] = !i_action && used[s] && ev_in[s] != EV_REST
                                   && ev_in[s] != EV_MUTED && ev_in[s] != EV_STOPPED;
        end
        fx_event = (i_effect_code == FX_INSTR) || (i_effect_code == FX_CHORUS)
                || (i_effect_code == FX_PAN) || (i_effect_code == FX_REVERB);
        n_pend[NSTR] = !i_action && fx_event;
        tick_sum = SW'(r_acc) + HALF;
    end

    // slot length dividend, rounded to nearest
    always_comb begin
        num_eff   = (i_region_numerator == 8'h00) ? 8'h01 : i_region_numerator;
        prod      = DW'(i_region_denominator) * DW'(TICKS_PER_SLOT);
        dividend  = (prod << FRACTION_BITS) + DW'(num_eff >> 1);
        div_start = i_cmd.load && !i_action;
    end

    tstm_div #(.DW(DW)) u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (div_start),
        .i_dividend (dividend),
        .i_divisor  (num_eff),
        .o_done     (div_done),
        .o_quotient (quotient)
    );

    // lowest pending event first: offs, effect, ons
    always_comb begin
        pidx = '0;
        for (int i = PEND_W - 1; i >= 0; i--) begin
            if (r_pend[i]) pidx = PIDX_W'(i);
        end
        pick = PEND_W'(1) << pidx;
        on_i = pidx - PIDX_W'(NSTR + 1);
        sel_s = (pidx < PIDX_W'(NSTR)) ? pidx[2:0] : on_i[2:0];
        sel_off  = '0;
        sel_ev   = '0;
        sel_tune = '0;
        for (int s = 0; s < NSTR; s++) begin
            if (sel_s == 3'(s)) begin
                sel_off  = r_off[s];
                sel_ev   = r_ev[s];
                sel_tune = r_tuning[8*s +: 8];
            end
        end
        dlt     = r_tick - r_prev;
        dlt_sat = (dlt[TICK_W-1:DELTA_W] != '0) ? '1 : dlt[DELTA_W-1:0];
    end

    // event fields
    always_comb begin
        e_cnt  = 2'd2;
        e_d2   = 8'h00;
        e_stat = ST_NOTE_OFF;
        e_d1   = note_of(sel_off, sel_tune, r_transpose, sel_s);
        if (pidx == PIDX_W'(NSTR)) begin
            e_stat = ST_CONTROL;
            e_d2   = r_val;
            case (r_code)
                FX_INSTR: begin
                    e_stat = ST_PROGRAM;
                    e_d1   = {1'b0, r_prog};
                    e_d2   = 8'h00;
                    e_cnt  = 2'd1;
                end
                FX_CHORUS: e_d1 = CTL_CHORUS;
                FX_PAN:    e_d1 = CTL_PAN;
                default:   e_d1 = CTL_REVERB;
            endcase
        end else if (pidx > PIDX_W'(NSTR)) begin
            e_stat = ST_NOTE_ON;
            e_d1   = note_of(sel_ev, sel_tune, r_transpose, sel_s);
            e_d2   = r_vel;
        end
    end

    // configuration, track state and request state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_channel      <= '0;
            r_string_count <= 4'd6;
            r_tuning       <= '0;
            r_transpose    <= '0;
            r_acc          <= '0;
            r_prev         <= '0;
            r_nlr          <= 1'b0;
            r_prog         <= '0;
            r_vel          <= 8'd127;
            r_pend         <= '0;
            for (int s = 0; s < NSTR; s++) r_sound[s] <= '0;
        end else begin
            if (i_cfg_we) begin
                unique case (t_cfg_idx'(i_cfg_idx))
                    CFG_CHANNEL:    r_channel      <= i_cfg_data[3:0];
                    CFG_STRINGS:    r_string_count <= i_cfg_data[3:0];
                    CFG_INSTRUMENT: begin
                        r_nlr  <= i_cfg_data[7];
                        r_prog <= i_cfg_data[6:0];
                    end
                    CFG_VOLUME:     r_vel          <= i_cfg_data[7:0];
                    CFG_TUNING:     r_tuning       <= i_cfg_data;
                    CFG_TRANSPOSE:  r_transpose    <= i_cfg_data[7:0];
                    default: ;
                endcase
            end
            if (i_cmd.load) begin
                r_pend <= n_pend;
                for (int s = 0; s < NSTR; s++) r_sound[s] <= n_sound[s];
                if (!i_action && i_effect_code == FX_INSTR) begin
                    r_nlr  <= i_effect_value[7];
                    r_prog <= i_effect_value[6:0];
                end
                if (!i_action && i_effect_code == FX_VOLUME) begin
                    r_vel <= i_effect_value;
                end
            end
            if (i_cmd.emit) begin
                r_pend <= r_pend & ~pick;
                r_prev <= r_tick;
            end
            if (i_cmd.commit && !r_flush) begin
                r_acc <= r_acc + ACC_W'(quotient);
            end
        end
    end

    // request payload capture
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_code  <= i_effect_code;
            r_val   <= i_effect_value;
            r_flush <= i_action;
            r_tick  <= tick_sum[FRACTION_BITS +: TICK_W];
            for (int s = 0; s < NSTR; s++) begin
                r_ev[s]  <= ev_in[s];
                r_off[s] <= n_off[s];
            end
        end
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ovalid <= 1'b0;
        end else if (i_cmd.emit) begin
            r_ovalid <= 1'b1;
        end else if (i_out_ready) begin
            r_ovalid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.emit) begin
            r_odelta <= dlt_sat;
            r_ostat  <= {e_stat, r_channel};
            r_od1    <= e_d1;
            r_od2    <= e_d2;
            r_ocnt   <= e_cnt;
            r_olast  <= ((r_pend & ~pick) == '0);
        end
    end

    assign o_status.pend_any = (r_pend != '0);
    assign o_status.div_done = div_done;
    assign o_status.out_free = !r_ovalid || i_out_ready;

    assign o_out_valid   = r_ovalid;
    assign o_delta_ticks = r_odelta;
    assign o_status_byte = r_ostat;
    assign o_data_one    = r_od1;
    assign o_data_two    = r_od2;
    assign o_data_count  = r_ocnt;
    assign o_last_event  = r_olast;
endmodule

// ----- sv/tab_space_to_midi_events_unit.sv -----
// tab_space_to_midi_events_unit: top level, tablature slots in, midi events out
//
//   channel   dir  handshake          payload
//   i_slot    in   valid / ready      action, string events, effect, tuplet ratio
//   o_event   out  valid / ready      delta, status, data bytes, count, last flag
//   i_cfg_*   in   write enable only  register index, 64-bit data
//
// a slot is accepted, then its events are issued while the serial divider runs, then
// it is committed; DW = 8 + clog2(TICKS_PER_SLOT+1) + FRACTION_BITS + 1 is the
// divider's dividend width (30 at the defaults); a flush issues its events and commits.
// each stall of the event register stretches the event phase, which lengthens the
// slot only once that phase outlasts the divider.
// synchronous active-low reset clears all track state at once, no clearing pass.
`timescale 1ns / 1ps
module tab_space_to_midi_events_unit #(
    parameter int unsigned STRINGS        = 8,
    parameter int unsigned TICKS_PER_SLOT = 24,
    parameter int unsigned FRACTION_BITS  = 16
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [2:0]  i_cfg_idx,
    input  logic [63:0] i_cfg_data,
    tstm_slot_if.sink   i_slot,
    tstm_event_if.source o_event
);
    import tstm_pkg::*;

    t_cmd    cmd;
    t_status status;

    tstm_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_req_valid (i_slot.valid),
        .o_req_ready (i_slot.ready),
        .i_status    (status),
        .o_cmd       (cmd)
    );

    tstm_dp #(
        .STRINGS        (STRINGS),
        .TICKS_PER_SLOT (TICKS_PER_SLOT),
        .FRACTION_BITS  (FRACTION_BITS)
    ) u_dp (
        .i_clk                (i_clk),
        .i_rst_n              (i_rst_n),
        .i_cfg_we             (i_cfg_we),
        .i_cfg_idx            (i_cfg_idx),
        .i_cfg_data           (i_cfg_data),
        .i_action             (i_slot.action),
        .i_string_events      (i_slot.string_events),
        .i_effect_code        (i_slot.effect_code),
        .i_effect_value       (i_slot.effect_value),
        .i_region_denominator (i_slot.region_denominator),
        .i_region_numerator   (i_slot.region_numerator),
        .i_cmd                (cmd),
        .o_status             (status),
        .i_out_ready          (o_event.ready),
        .o_out_valid          (o_event.valid),
        .o_delta_ticks        (o_event.delta_ticks),
        .o_status_byte        (o_event.status_byte),
        .o_data_one           (o_event.data_one),
        .o_data_two           (o_event.data_two),
        .o_data_count         (o_event.data_count),
        .o_last_event         (o_event.last_event)
    );
endmodule

// ----- sv/tstm_chk.sv -----
// tstm_chk: port-level assertions for the tab slot to midi event unit
`timescale 1ns / 1ps
module tstm_chk (
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       i_in_valid,
    input logic       i_in_ready,
    input logic       i_out_valid,
    input logic       i_out_ready,
    input logic [7:0] i_status_byte,
    input logic [1:0] i_data_count
);
    // one request at a time: no new accept right after one
    a_one_req: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && i_in_ready |=> !i_in_ready)
        else $error("request accepted back to back");

    // nothing is shown in the cycle after reset
    a_rst_quiet: assert property (@(posedge i_clk)
        $past(!i_rst_n) |-> !i_out_valid)
        else $error("event valid after reset");

    // a stalled event stays shown
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid && $stable(i_status_byte))
        else $error("stalled event dropped or changed");

    // program change carries one data byte, everything else two
    a_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid |-> ((i_data_count == 2'd1) == (i_status_byte[7:4] == 4'hc))
                        && (i_data_count == 2'd1 || i_data_count == 2'd2))
        else $error("data count does not match status");
endmodule

bind tab_space_to_midi_events_unit tstm_chk u_chk (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .i_in_valid    (i_slot.valid),
    .i_in_ready    (i_slot.ready),
    .i_out_valid   (o_event.valid),
    .i_out_ready   (o_event.ready),
    .i_status_byte (o_event.status_byte),
    .i_data_count  (o_event.data_count)
);
